@@ design/gtg_pkg.sv @@
// gtg_pkg: shared types and constants for the go-to-goal proportional controller
// holds the sequencer and cordic state encodings, config register codes and the arctangent table
// no dependencies
package gtg_pkg;

  // field widths
  localparam int unsigned POS_W     = 24;
  localparam int unsigned DIFF_W    = 25;
  localparam int unsigned SUMSQ_W   = 50;
  localparam int unsigned DIST_W    = 25;
  localparam int unsigned HEAD_W    = 16;
  localparam int unsigned DIR_W     = 17;
  localparam int unsigned HERR_W    = 18;
  localparam int unsigned GAIN_W    = 12;
  localparam int unsigned LIN_W     = 29;
  localparam int unsigned ANG_W     = 21;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // cordic geometry: angles in Q.61
  localparam int unsigned ANG_FRAC     = 61;
  localparam int unsigned CORDIC_STEPS = 61;
  localparam int unsigned STEP_W       = 6;
  localparam int unsigned XY_W         = 63;
  localparam int unsigned Z_W          = 64;
  localparam int unsigned A_W          = 65;
  localparam int unsigned NORM_BIT     = 59;

  // largest value that can still be multiplied by nine in 64 bits
  localparam logic [63:0] P3_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'd9;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINEAR_GAIN  = 2'd0,
    CFG_ANGULAR_GAIN = 2'd1,
    CFG_ARRIVE_TOL   = 2'd2,
    CFG_ACTIVE       = 2'd3
  } cfg_reg_t;

  // top-level sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_CMP,
    ST_CORD_GO,
    ST_CORD_WAIT,
    ST_HERR,
    ST_MUL,
    ST_LOAD
  } seq_state_t;

  // cordic unit sequencer
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_NORM,
    CS_ITER,
    CS_OCTANT,
    CS_HALF,
    CS_SIGN,
    CS_ROUND,
    CS_DONE
  } cord_state_t;

  typedef logic signed [Z_W-1:0] atan_tab_t [CORDIC_STEPS];

  // shift-subtract quotient, only used while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    int          i;
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q.61 by truncated power series, entry 0 is atan(1/2) + atan(1/3)
  function automatic atan_tab_t atan_table();
    atan_tab_t        t;
    logic [63:0]      term;
    logic [63:0]      p3;
    logic signed [63:0] acc;
    int unsigned      i;
    int unsigned      k;
    logic             stop;
    for (i = 1; i < CORDIC_STEPS; i++) begin
      acc = '0;
      for (k = 0; k < 64; k++) begin
        if (i * (2 * k + 1) <= ANG_FRAC) begin
          term = udiv64(64'd1 << (ANG_FRAC - i * (2 * k + 1)), 64'(2 * k + 1));
          acc  = k[0] ? acc - signed'(term) : acc + signed'(term);
        end
      end
      t[i] = acc;
    end
    acc  = '0;
    p3   = 64'd3;
    stop = 1'b0;
    for (k = 0; k < 64; k++) begin
      if (!stop) begin
        term = udiv64(udiv64(64'd1 << ANG_FRAC, p3), 64'(2 * k + 1));
        if (term == 64'd0) begin
          stop = 1'b1;
        end else begin
          acc = k[0] ? acc - signed'(term) : acc + signed'(term);
          if (p3 > P3_LIMIT) begin
            stop = 1'b1;
          end else begin
            p3 = p3 * 64'd9;
          end
        end
      end
    end
    t[0] = t[1] + acc;
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

endpackage

@@ design/go_to_goal_p_controller.sv @@
// go_to_goal_p_controller: top level, stream ports, config registers and item sequencer
// depends on gtg_pkg, gtg_sqrt and gtg_cordic
//
// Takes one robot pose and goal per transaction and returns one speed command.
// Items are handled one at a time: an item that is within tolerance needs only the
// bit-serial square root (two radicand bits per cycle), a moving item also the
// cordic unit, which normalizes its operands one bit per cycle and then runs
// 61 micro-rotations. A finished result sits in an output register, so the next item
// is accepted while it waits. Arrived flags are cleared only by reset.
module go_to_goal_p_controller #(
  parameter int unsigned MAX_ROBOTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [gtg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gtg_pkg::CFG_DAT_W-1:0]     cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // current_x, current_y, current_heading, goal_x, goal_y
  input  logic [2:0]   s_tuser,  // robot_index
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata   // linear_speed, angular_speed, arrived, all_arrived, zero fill
);

  gtg_pkg::seq_state_t state, state_next;

  // config registers
  logic [gtg_pkg::GAIN_W-1:0]    linear_gain, angular_gain;
  logic [gtg_pkg::POS_W-1:0]     arrive_tolerance;
  logic [3:0]                    active_robots;

  // item registers
  logic [2:0]                          robot_index;
  logic signed [gtg_pkg::POS_W-1:0]    cx, cy, gx, gy;
  logic signed [gtg_pkg::HEAD_W-1:0]   heading;
  logic signed [gtg_pkg::DIFF_W-1:0]   dx, dy;
  logic [gtg_pkg::SUMSQ_W-1:0]         sumsq;
  logic [gtg_pkg::DIST_W-1:0]          distance;
  logic signed [gtg_pkg::HERR_W-1:0]   herr;
  logic                                is_arrived;
  logic [gtg_pkg::LIN_W-1:0]           lin;
  logic [gtg_pkg::ANG_W-1:0]           ang;
  logic [MAX_ROBOTS-1:0]               flags;

  // output register
  logic                          out_valid;
  logic [gtg_pkg::LIN_W-1:0]     out_lin;
  logic [gtg_pkg::ANG_W-1:0]     out_ang;
  logic                          out_arrived, out_all;

  // unit handshakes
  logic                                sqrt_start, sqrt_done;
  logic [gtg_pkg::DIST_W-1:0]          sqrt_root;
  logic                                cord_start, cord_done;
  logic signed [gtg_pkg::DIR_W-1:0]    cord_dir;
  logic [gtg_pkg::DIFF_W-1:0]          abs_dx, abs_dy;

  // datapath helpers
  logic [2*gtg_pkg::DIFF_W-1:0]        sq_x, sq_y;
  logic [gtg_pkg::GAIN_W+gtg_pkg::DIST_W-1:0] lin_prod;
  logic signed [gtg_pkg::GAIN_W+gtg_pkg::HERR_W:0] ang_prod;
  logic                                all_now;
  logic                                load_ok;

  assign abs_dx = dx[gtg_pkg::DIFF_W-1] ? gtg_pkg::DIFF_W'(-dx) : gtg_pkg::DIFF_W'(dx);
  assign abs_dy = dy[gtg_pkg::DIFF_W-1] ? gtg_pkg::DIFF_W'(-dy) : gtg_pkg::DIFF_W'(dy);

  always_comb begin
    sq_x     = unsigned'((2*gtg_pkg::DIFF_W)'(dx) * (2*gtg_pkg::DIFF_W)'(dx));
    sq_y     = unsigned'((2*gtg_pkg::DIFF_W)'(dy) * (2*gtg_pkg::DIFF_W)'(dy));
    lin_prod = linear_gain * distance + (gtg_pkg::GAIN_W + gtg_pkg::DIST_W)'(128);
    ang_prod = signed'({1'b0, angular_gain}) * herr
             + (gtg_pkg::GAIN_W + gtg_pkg::HERR_W + 1)'(128);
  end

  // all active robots arrived
  always_comb begin
    all_now = 1'b1;
    for (int k = 0; k < MAX_ROBOTS; k++) begin
      if ((k < 32'(active_robots)) && !flags[k]) all_now = 1'b0;
    end
  end

  assign load_ok = !out_valid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gtg_pkg::ST_IDLE:      if (s_tvalid) state_next = gtg_pkg::ST_DIFF;
      gtg_pkg::ST_DIFF:      state_next = gtg_pkg::ST_SQUARE;
      gtg_pkg::ST_SQUARE:    state_next = gtg_pkg::ST_SQRT_GO;
      gtg_pkg::ST_SQRT_GO:   state_next = gtg_pkg::ST_SQRT_WAIT;
      gtg_pkg::ST_SQRT_WAIT: if (sqrt_done) state_next = gtg_pkg::ST_CMP;
      gtg_pkg::ST_CMP:
        state_next = (distance > arrive_tolerance) ? gtg_pkg::ST_CORD_GO : gtg_pkg::ST_LOAD;
      gtg_pkg::ST_CORD_GO:   state_next = gtg_pkg::ST_CORD_WAIT;
      gtg_pkg::ST_CORD_WAIT: if (cord_done) state_next = gtg_pkg::ST_HERR;
      gtg_pkg::ST_HERR:      state_next = gtg_pkg::ST_MUL;
      gtg_pkg::ST_MUL:       state_next = gtg_pkg::ST_LOAD;
      gtg_pkg::ST_LOAD:      if (load_ok) state_next = gtg_pkg::ST_IDLE;
      default:               state_next = gtg_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = (state == gtg_pkg::ST_IDLE);
    sqrt_start = (state == gtg_pkg::ST_SQRT_GO);
    cord_start = (state == gtg_pkg::ST_CORD_GO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain      <= gtg_pkg::GAIN_W'(128);
      angular_gain     <= gtg_pkg::GAIN_W'(1024);
      arrive_tolerance <= gtg_pkg::POS_W'(66);
      active_robots    <= 4'd5;
    end else if (cfg_we) begin
      case (gtg_pkg::cfg_reg_t'(cfg_index))
        gtg_pkg::CFG_LINEAR_GAIN:  linear_gain      <= cfg_data[gtg_pkg::GAIN_W-1:0];
        gtg_pkg::CFG_ANGULAR_GAIN: angular_gain     <= cfg_data[gtg_pkg::GAIN_W-1:0];
        gtg_pkg::CFG_ARRIVE_TOL:   arrive_tolerance <= cfg_data;
        gtg_pkg::CFG_ACTIVE:       active_robots    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      gtg_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          robot_index <= s_tuser;
          cx          <= s_tdata[23:0];
          cy          <= s_tdata[47:24];
          heading     <= s_tdata[63:48];
          gx          <= s_tdata[87:64];
          gy          <= s_tdata[111:88];
        end
      end
      gtg_pkg::ST_DIFF: begin
        dx <= gtg_pkg::DIFF_W'(gx) - gtg_pkg::DIFF_W'(cx);
        dy <= gtg_pkg::DIFF_W'(gy) - gtg_pkg::DIFF_W'(cy);
      end
      gtg_pkg::ST_SQUARE: sumsq <= gtg_pkg::SUMSQ_W'(sq_x) + gtg_pkg::SUMSQ_W'(sq_y);
      gtg_pkg::ST_SQRT_WAIT: if (sqrt_done) distance <= sqrt_root;
      gtg_pkg::ST_CMP: begin
        is_arrived <= !(distance > arrive_tolerance);
        lin        <= '0;
        ang        <= '0;
      end
      gtg_pkg::ST_HERR: herr <= gtg_pkg::HERR_W'(cord_dir) - gtg_pkg::HERR_W'(heading);
      gtg_pkg::ST_MUL: begin
        lin <= lin_prod[gtg_pkg::LIN_W+7:8];
        ang <= ang_prod[gtg_pkg::ANG_W+7:8];
      end
      default: ;
    endcase
  end

  // sticky arrived flags
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (state == gtg_pkg::ST_CMP && !(distance > arrive_tolerance)) begin
      for (int k = 0; k < MAX_ROBOTS; k++) begin
        if (32'(robot_index) == k) flags[k] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == gtg_pkg::ST_LOAD && load_ok) begin
      out_valid   <= 1'b1;
      out_lin     <= lin;
      out_ang     <= ang;
      out_arrived <= is_arrived;
      out_all     <= all_now;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_all, out_arrived, out_ang, out_lin};

  gtg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sumsq),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  gtg_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .start     (cord_start),
    .abs_x     (abs_dx),
    .abs_y     (abs_dy),
    .neg_x     (dx[gtg_pkg::DIFF_W-1]),
    .neg_y     (dy[gtg_pkg::DIFF_W-1]),
    .done      (cord_done),
    .direction (cord_dir)
  );

endmodule

@@ design/gtg_sqrt.sv @@
// gtg_sqrt: bit-serial square root, two radicand bits per cycle, rounded to nearest
// uses gtg_pkg for widths
module gtg_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gtg_pkg::SUMSQ_W-1:0]   radicand,
  output logic                          done,
  output logic [gtg_pkg::DIST_W-1:0]    root
);

  localparam int unsigned STEPS = gtg_pkg::SUMSQ_W / 2;
  localparam int unsigned REM_W = gtg_pkg::DIST_W + 2;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [gtg_pkg::SUMSQ_W-1:0] rad;
  logic [REM_W-1:0]            rem;
  logic [gtg_pkg::DIST_W-1:0]  acc;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        fin;

  logic [REM_W+1:0]            rem_sh;
  logic [REM_W+1:0]            trial;
  logic                        take;

  // one result digit per cycle
  always_comb begin
    rem_sh = {rem, rad[gtg_pkg::SUMSQ_W-1 -: 2]};
    trial  = {2'b00, acc, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        acc  <= '0;
      end else if (busy) begin
        rad <= {rad[gtg_pkg::SUMSQ_W-3:0], 2'b00};
        if (take) begin
          rem <= REM_W'(rem_sh - trial);
          acc <= {acc[gtg_pkg::DIST_W-2:0], 1'b1};
        end else begin
          rem <= REM_W'(rem_sh);
          acc <= {acc[gtg_pkg::DIST_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // round up when the remainder exceeds the floor root
  assign root = acc + gtg_pkg::DIST_W'(REM_W'(acc) < rem);
  assign done = fin;

endmodule

@@ design/gtg_cordic.sv @@
// gtg_cordic: iterative vectoring cordic giving atan2 rounded to Q2.13
// one micro-rotation per cycle, operands normalized one bit per cycle; uses gtg_pkg
module gtg_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [gtg_pkg::DIFF_W-1:0]        abs_x,
  input  logic [gtg_pkg::DIFF_W-1:0]        abs_y,
  input  logic                              neg_x,
  input  logic                              neg_y,
  output logic                              done,
  output logic signed [gtg_pkg::DIR_W-1:0]  direction
);

  localparam logic signed [gtg_pkg::A_W-1:0] QUARTER =
    gtg_pkg::A_W'(gtg_pkg::ATAN_TAB[0]);
  localparam logic signed [gtg_pkg::A_W-1:0] HALF_ROUND =
    gtg_pkg::A_W'(1) <<< (gtg_pkg::ANG_FRAC - 14);

  gtg_pkg::cord_state_t state, state_next;

  logic signed [gtg_pkg::XY_W-1:0]  x, y;
  logic signed [gtg_pkg::Z_W-1:0]   z;
  logic signed [gtg_pkg::A_W-1:0]   a;
  logic [gtg_pkg::STEP_W-1:0]       step;
  logic                             swap, nx_q, ny_q;
  logic signed [gtg_pkg::DIR_W-1:0] dir;

  logic signed [gtg_pkg::XY_W-1:0]  xs, ys;
  logic signed [gtg_pkg::Z_W-1:0]   tab_val;
  logic signed [gtg_pkg::A_W-1:0]   a_rnd;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gtg_pkg::CS_IDLE:   if (start) state_next = gtg_pkg::CS_NORM;
      gtg_pkg::CS_NORM:   if (x[gtg_pkg::NORM_BIT]) state_next = gtg_pkg::CS_ITER;
      gtg_pkg::CS_ITER:
        if (step == gtg_pkg::STEP_W'(gtg_pkg::CORDIC_STEPS - 1)) begin
          state_next = gtg_pkg::CS_OCTANT;
        end
      gtg_pkg::CS_OCTANT: state_next = gtg_pkg::CS_HALF;
      gtg_pkg::CS_HALF:   state_next = gtg_pkg::CS_SIGN;
      gtg_pkg::CS_SIGN:   state_next = gtg_pkg::CS_ROUND;
      gtg_pkg::CS_ROUND:  state_next = gtg_pkg::CS_DONE;
      gtg_pkg::CS_DONE:   state_next = gtg_pkg::CS_IDLE;
      default:            state_next = gtg_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state == gtg_pkg::CS_DONE);
  end
  assign direction = dir;

  // micro-rotation datapath
  always_comb begin
    xs      = x >>> step;
    ys      = y >>> step;
    tab_val = gtg_pkg::ATAN_TAB[step];
    a_rnd   = (a + HALF_ROUND) >>> (gtg_pkg::ANG_FRAC - 13);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtg_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gtg_pkg::CS_IDLE: begin
        // fold into first octant
        if (start) begin
          swap <= abs_y > abs_x;
          nx_q <= neg_x;
          ny_q <= neg_y;
          x    <= gtg_pkg::XY_W'((abs_y > abs_x) ? abs_y : abs_x);
          y    <= gtg_pkg::XY_W'((abs_y > abs_x) ? abs_x : abs_y);
          z    <= '0;
          step <= '0;
        end
      end
      gtg_pkg::CS_NORM: begin
        if (!x[gtg_pkg::NORM_BIT]) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      gtg_pkg::CS_ITER: begin
        if (!y[gtg_pkg::XY_W-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tab_val;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tab_val;
        end
        step <= step + 1'b1;
      end
      gtg_pkg::CS_OCTANT: a <= swap ? (QUARTER <<< 1) - gtg_pkg::A_W'(z) : gtg_pkg::A_W'(z);
      gtg_pkg::CS_HALF:   if (nx_q) a <= (QUARTER <<< 2) - a;
      gtg_pkg::CS_SIGN:   if (ny_q) a <= -a;
      gtg_pkg::CS_ROUND:  dir <= gtg_pkg::DIR_W'(a_rnd);
      default: ;
    endcase
  end

endmodule
